>>> design/hrs_pkg.sv
// Shared types, codes and helper functions for the HTTP response header splitter.
// Used by hrs_front, hrs_fifo, hrs_back and the top level; depends on nothing else.
package hrs_pkg;

    localparam int FIFO_DEPTH_DEF = 4;
    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [9:0] CODE_MAX = 10'd1023;
    localparam logic [9:0] CODE_OK = 10'd200;
    localparam logic [9:0] CODE_NOTFOUND = 10'd404;
    localparam logic [9:0] CODE_DUP = 10'd409;
    localparam logic [7:0] HDR_LIMIT_RST = 8'd32;
    localparam logic [13:0] MAX_LINE_LEN_RST = 14'd4096;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        CFG_HDR_LIMIT    = 2'd0,
        CFG_MAX_LINE_LEN = 2'd1,
        CFG_UNUSED_2     = 2'd2,
        CFG_UNUSED_3     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_STATUS  = 2'd0,
        PH_HEADERS = 2'd1,
        PH_BODY    = 2'd2,
        PH_STOPPED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        SCAN_SPACE  = 2'd0,
        SCAN_BLANKS = 2'd1,
        SCAN_DIGITS = 2'd2,
        SCAN_DONE   = 2'd3
    } scan_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STATUS_OK = 3'd1,
        EV_HEADER    = 3'd2,
        EV_END       = 3'd3,
        EV_BODY      = 3'd4,
        EV_PARSE_ERR = 3'd5,
        EV_TOO_LONG  = 3'd6,
        EV_TOO_MANY  = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        CLASS_OK       = 2'd0,
        CLASS_NOTFOUND = 2'd1,
        CLASS_DUP      = 2'd2,
        CLASS_OTHER    = 2'd3
    } status_class_t;

    // Everything the back end needs to know about one byte.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_blank;
        logic       is_space;
        logic       is_cr;
        logic       is_lf;
    } chr_t;

    typedef struct packed {
        logic start;
        chr_t ch;
    } hrs_item_t;

    typedef struct packed {
        phase_t        phase;
        logic [2:0]    prefix_matched;
        logic          prefix_bad;
        scan_t         code_scan;
        logic [9:0]    code_value;
        logic          cr_pending;
        logic [14:0]   line_count;
        logic [7:0]    header_count;
        status_class_t status_class;
    } hrs_state_t;

    function automatic chr_t classify(input logic [7:0] c);
        chr_t r;
        r.data     = c;
        r.lower    = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        r.is_digit = (c >= 8'h30 && c <= 8'h39);
        r.digit    = 4'(c - 8'h30);
        r.is_space = (c == 8'h20);
        r.is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        r.is_cr    = (c == CHAR_CR);
        r.is_lf    = (c == CHAR_LF);
        return r;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h68;
            3'd1:    r = 8'h74;
            3'd2:    r = 8'h74;
            3'd3:    r = 8'h70;
            3'd4:    r = 8'h2F;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic hrs_state_t clear_state();
        hrs_state_t r;
        r.phase          = PH_STATUS;
        r.prefix_matched = 3'd0;
        r.prefix_bad     = 1'b0;
        r.code_scan      = SCAN_SPACE;
        r.code_value     = 10'd0;
        r.cr_pending     = 1'b0;
        r.line_count     = 15'd0;
        r.header_count   = 8'd0;
        r.status_class   = CLASS_OK;
        return r;
    endfunction

endpackage

>>> design/http_response_header_splitter.sv
// Top level of the HTTP response header splitter: configuration registers and wiring
// of the front end, the queue and the back end. Depends on hrs_pkg, hrs_front,
// hrs_fifo and hrs_back.
//
//  channel  handshake            payload
//  input    in_valid / in_stall  start_of_response, data_byte
//  output   out_valid/ out_stall event_res, request_status, header_index,
//                                line_length, body_data
//  config   cfg_write_en         cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; a request is written into the queue
// at the accepting edge and parsed into the output register when the back end pops it.
// The parser stage does the whole per-byte update combinationally, which sets the rate.
// Reset clears the parse state and the queue, and loads a header limit of 32 and
// max_line_len 4096.
// in_stall rises only when the FIFO_DEPTH-entry queue is full; out_stall holds the
// output register and lets the queue fill behind it.
module http_response_header_splitter
    import hrs_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_of_response,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [1:0]  request_status,
    output logic [7:0]  header_index,
    output logic [14:0] line_length,
    output logic [7:0]  body_data,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    logic [7:0]  hdr_limit_reg, hdr_limit_next;
    logic [13:0] max_line_len_reg, max_line_len_next;

    logic      push;
    hrs_item_t push_item;
    logic      pop;
    hrs_item_t pop_item;
    logic      fifo_full;
    logic      fifo_empty;

    always_comb
    begin
        hdr_limit_next    = hdr_limit_reg;
        max_line_len_next = max_line_len_reg;
        if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HDR_LIMIT:    hdr_limit_next    = cfg_data[7:0];
                CFG_MAX_LINE_LEN: max_line_len_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_limit_reg    <= HDR_LIMIT_RST;
            max_line_len_reg <= MAX_LINE_LEN_RST;
        end
        else
        begin
            hdr_limit_reg    <= hdr_limit_next;
            max_line_len_reg <= max_line_len_next;
        end
    end

    hrs_front u_front (
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .start_of_response (start_of_response),
        .data_byte         (data_byte),
        .fifo_full         (fifo_full),
        .push              (push),
        .push_item         (push_item)
    );

    hrs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    hrs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr_limit      (hdr_limit_reg),
        .max_line_len   (max_line_len_reg),
        .fifo_empty     (fifo_empty),
        .pop_item       (pop_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .request_status (request_status),
        .header_index   (header_index),
        .line_length    (line_length),
        .body_data      (body_data)
    );

endmodule

>>> design/hrs_front.sv
// Front end: takes request bytes, classifies them and pushes them into the queue.
// Depends on hrs_pkg.
module hrs_front
    import hrs_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       start_of_response,
    input  logic [7:0] data_byte,
    input  logic       fifo_full,
    output logic       push,
    output hrs_item_t  push_item
);

    assign in_stall = fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        push_item.start = start_of_response;
        push_item.ch    = classify(data_byte);
    end

endmodule

>>> design/hrs_fifo.sv
// Short queue of classified bytes between the front and back ends.
// Depends on hrs_pkg.
module hrs_fifo
    import hrs_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hrs_item_t push_item,
    input  logic      pop,
    output hrs_item_t pop_item,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrs_item_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on push");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not fall on pop");
`endif

endmodule

>>> design/hrs_back.sv
// Back end: runs the response parser on queued bytes and holds the output register.
// Depends on hrs_pkg.
module hrs_back
    import hrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  hdr_limit,
    input  logic [13:0] max_line_len,
    input  logic        fifo_empty,
    input  hrs_item_t   pop_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [1:0]  request_status,
    output logic [7:0]  header_index,
    output logic [14:0] line_length,
    output logic [7:0]  body_data
);

    hrs_state_t  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    event_t      event_reg, event_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  hidx_reg, hidx_next;
    logic [14:0] len_reg, len_next;
    logic [7:0]  body_reg, body_next;

    function automatic hrs_state_t status_char(input hrs_state_t s, input chr_t ch);
        hrs_state_t r;
        logic [13:0] v;
        r = s;
        v = 14'(s.code_value) * 14'd10 + 14'(ch.digit);
        if (s.prefix_matched < PREFIX_LEN)
        begin
            if (ch.lower != prefix_char(s.prefix_matched))
            begin
                r.prefix_bad = 1'b1;
            end
            r.prefix_matched = s.prefix_matched + 3'd1;
        end
        case (s.code_scan)
            SCAN_SPACE:
            begin
                if (ch.is_space)
                begin
                    r.code_scan = SCAN_BLANKS;
                end
            end
            SCAN_BLANKS:
            begin
                if (ch.is_digit)
                begin
                    r.code_value = 10'(ch.digit);
                    r.code_scan  = SCAN_DIGITS;
                end
                else if (!ch.is_blank)
                begin
                    r.code_scan = SCAN_DONE;
                end
            end
            SCAN_DIGITS:
            begin
                if (ch.is_digit)
                begin
                    r.code_value = (v > 14'(CODE_MAX)) ? CODE_MAX : v[9:0];
                end
                else
                begin
                    r.code_scan = SCAN_DONE;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // One content byte: bump the saturating line length, then, in the status phase, feed the status scanner.
    function automatic hrs_state_t content(input hrs_state_t s, input chr_t ch,
                                           input logic [13:0] maxlen);
        hrs_state_t r;
        r = s;
        if (s.line_count < 15'(maxlen) + 15'd1)
        begin
            r.line_count = s.line_count + 15'd1;
        end
        if (s.phase == PH_STATUS)
        begin
            r = status_char(r, ch);
        end
        return r;
    endfunction

    assign pop = !fifo_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        hrs_state_t s;
        event_t ev;
        logic ok;
        s         = pop_item.start ? clear_state() : state_reg;
        ev        = EV_NONE;
        ok        = 1'b0;
        hidx_next = 8'd0;
        len_next  = 15'd0;
        body_next = 8'd0;

        if (s.phase == PH_STATUS || s.phase == PH_HEADERS)
        begin
            if (s.cr_pending && pop_item.ch.is_lf)
            begin
                s.cr_pending = 1'b0;
                len_next     = s.line_count;
                s.line_count = 15'd0;
                if (s.phase == PH_STATUS)
                begin
                    ok = (s.prefix_matched == PREFIX_LEN) && !s.prefix_bad
                         && (s.code_scan == SCAN_DIGITS || s.code_scan == SCAN_DONE)
                         && (s.code_value != 10'd0);
                    if (!ok)
                    begin
                        s.status_class = CLASS_OTHER;
                        s.phase        = PH_STOPPED;
                        ev             = EV_PARSE_ERR;
                    end
                    else
                    begin
                        if (s.code_value == CODE_OK)
                        begin
                            s.status_class = CLASS_OK;
                        end
                        else if (s.code_value == CODE_NOTFOUND)
                        begin
                            s.status_class = CLASS_NOTFOUND;
                        end
                        else if (s.code_value == CODE_DUP)
                        begin
                            s.status_class = CLASS_DUP;
                        end
                        else
                        begin
                            s.status_class = CLASS_OTHER;
                        end
                        s.phase = PH_HEADERS;
                        ev      = EV_STATUS_OK;
                    end
                end
                else if (s.header_count >= hdr_limit)
                begin
                    ev      = EV_TOO_MANY;
                    s.phase = PH_STOPPED;
                end
                else if (len_next > 15'(max_line_len))
                begin
                    ev      = EV_TOO_LONG;
                    s.phase = PH_STOPPED;
                end
                else if (len_next == 15'd0)
                begin
                    ev      = EV_END;
                    s.phase = PH_BODY;
                end
                else
                begin
                    hidx_next      = s.header_count;
                    s.header_count = s.header_count + 8'd1;
                    ev             = EV_HEADER;
                end
            end
            else if (s.cr_pending)
            begin
                // A CR not followed by LF is ordinary line content.
                s = content(s, classify(CHAR_CR), max_line_len);
                if (!pop_item.ch.is_cr)
                begin
                    s.cr_pending = 1'b0;
                    s = content(s, pop_item.ch, max_line_len);
                end
            end
            else if (pop_item.ch.is_cr)
            begin
                s.cr_pending = 1'b1;
            end
            else
            begin
                s = content(s, pop_item.ch, max_line_len);
            end
        end
        else if (s.phase == PH_BODY)
        begin
            ev        = EV_BODY;
            body_next = pop_item.ch.data;
        end

        state_next  = s;
        event_next  = ev;
        status_next = s.status_class;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clear_state();
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            event_reg  <= event_next;
            status_reg <= status_next;
            hidx_reg   <= hidx_next;
            len_reg    <= len_next;
            body_reg   <= body_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = event_reg;
    assign request_status = status_reg;
    assign header_index   = hidx_reg;
    assign line_length    = len_reg;
    assign body_data      = body_reg;

`ifndef SYNTHESIS
    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !pop_item.start && state_reg.phase == PH_STOPPED) |=> event_reg == EV_NONE)
        else $error("stopped parser produced an event");
    a_header_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_reg == EV_HEADER) |-> line_length != 15'd0)
        else $error("header line reported with zero length");
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !pop_item.start) |=> state_reg.header_count >= $past(state_reg.header_count))
        else $error("header count went down without a new response");
`endif

endmodule
